// File: design/tsfc_pkg.sv
// tsfc_pkg: shared types and constants for the touch sample filter and calibration unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package tsfc_pkg;

   localparam int SAMPLE_BITS   = 12;
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int GAIN_BITS     = 24;
   localparam int OFFSET_BITS   = 16;
   localparam int WINDOW_BITS   = 12;
   localparam int PIXEL_BITS    = 16;
   localparam int RSP_DATA_BITS = 2 * PIXEL_BITS;
   localparam int FRAC_BITS     = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 24;
   localparam int GROUP_BITS    = 2;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_X_GAIN       = 3'd0,
      CSR_Y_GAIN       = 3'd1,
      CSR_X_OFFSET     = 3'd2,
      CSR_Y_OFFSET     = 3'd3,
      CSR_AGREE_WINDOW = 3'd4
   } csr_index_type;

   // Group order within one frame of readings
   typedef enum logic [GROUP_BITS-1:0] {
      GRP_X1 = 2'd0,
      GRP_Y1 = 2'd1,
      GRP_X2 = 2'd2,
      GRP_Y2 = 2'd3
   } group_type;

   typedef struct packed {
      logic signed [GAIN_BITS-1:0]   x_gain;
      logic signed [GAIN_BITS-1:0]   y_gain;
      logic signed [OFFSET_BITS-1:0] x_offset;
      logic signed [OFFSET_BITS-1:0] y_offset;
      logic [WINDOW_BITS-1:0]        agree_window;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT,
      ST_SUM,
      ST_DIV,
      ST_AVG,
      ST_CHECK,
      ST_MUL_X,
      ST_CAL_X,
      ST_MUL_Y,
      ST_CAL_Y,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// File: design/tsfc_front.sv
// tsfc_front: accepts raw readings, tracks slot and group, gathers one group of readings.
// Pushes a finished group with its group code into the job queue. Uses tsfc_pkg.
`default_nettype none

module tsfc_front #(
   parameter int N = 5
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [tsfc_pkg::SAMPLE_BITS-1:0] in_sample,
   input  wire logic                           in_restart,
   input  wire tsfc_pkg::queue_status_type     qstat,
   output logic                                push,
   output logic [N*tsfc_pkg::SAMPLE_BITS+tsfc_pkg::GROUP_BITS-1:0] push_data
);
   import tsfc_pkg::*;

   localparam int SW  = $clog2(N);
   localparam int SIW = $clog2(N - 1);

   logic [SW-1:0]          slot_ff, slot_in, slot_cur;
   group_type              group_ff, group_in, group_cur;
   logic [SAMPLE_BITS-1:0] store_ff [N-1];
   logic                   accept, last_slot;

   always_comb begin
      slot_cur  = in_restart ? '0 : slot_ff;
      group_cur = in_restart ? GRP_X1 : group_ff;
      in_ready  = !qstat.full;
      accept    = in_valid && in_ready;
      last_slot = (slot_cur == SW'(N - 1));
      push      = accept && last_slot;
      slot_in   = slot_ff;
      group_in  = group_ff;
      if (accept) begin
         if (last_slot) begin
            slot_in  = '0;
            group_in = group_type'(group_cur + 2'd1);
         end else begin
            slot_in  = slot_cur + SW'(1);
            group_in = group_cur;
         end
      end
   end

   // earlier slots come from the store, the closing reading straight from the port
   always_comb begin
      push_data = '0;
      for (int i = 0; i < N - 1; i++) begin
         push_data[i*SAMPLE_BITS +: SAMPLE_BITS] = store_ff[i];
      end
      push_data[(N-1)*SAMPLE_BITS +: SAMPLE_BITS] = in_sample;
      push_data[N*SAMPLE_BITS +: GROUP_BITS]      = group_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         group_ff <= GRP_X1;
      end else begin
         slot_ff  <= slot_in;
         group_ff <= group_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !last_slot) begin
         store_ff[slot_cur[SIW-1:0]] <= in_sample;
      end
   end

endmodule

`default_nettype wire

// File: design/tsfc_queue.sv
// tsfc_queue: two-entry job queue between front and back.
// Uses tsfc_pkg for the status struct.
`default_nettype none

module tsfc_queue #(
   parameter int W = 62
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [W-1:0]               push_data,
   input  wire logic                       pop,
   output logic [W-1:0]                    pop_data,
   output tsfc_pkg::queue_status_type      qstat
);
   import tsfc_pkg::*;

   logic [W-1:0] entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   always_comb begin
      qstat.full  = (count_ff == 2'd2);
      qstat.empty = (count_ff == 2'd0);
      do_push     = push && !qstat.full;
      do_pop      = pop && !qstat.empty;
      pop_data    = entry_ff[rd_ptr_ff];
      wr_ptr_in   = wr_ptr_ff ^ do_push;
      rd_ptr_in   = rd_ptr_ff ^ do_pop;
      count_in    = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: design/tsfc_back.sv
// tsfc_back: sorts a group, takes the trimmed mean, checks agreement and calibrates.
// Holds the output register of the result channel. Uses tsfc_pkg.
`default_nettype none

module tsfc_back #(
   parameter int N = 5,
   parameter int T = 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tsfc_pkg::queue_status_type     qstat,
   input  wire logic [N*tsfc_pkg::SAMPLE_BITS+tsfc_pkg::GROUP_BITS-1:0] job_data,
   output logic                                job_pop,
   input  wire tsfc_pkg::cfg_type              cfg,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic [tsfc_pkg::PIXEL_BITS-1:0]     out_x,
   output logic [tsfc_pkg::PIXEL_BITS-1:0]     out_y,
   output logic                                out_accepted
);
   import tsfc_pkg::*;

   localparam int T_EFF  = (2 * T >= N) ? (N - 1) / 2 : T;
   localparam int D      = N - 2 * T_EFF;
   localparam int SUM_W  = $clog2(N * ((1 << SAMPLE_BITS) - 1) + 1);
   localparam int SH     = SUM_W + $clog2(D);
   localparam int RECIP  = ((1 << SH) + D - 1) / D;
   localparam int RW     = SH + 1;
   localparam int QW     = SUM_W + RW;
   localparam int CW     = $clog2(N);
   localparam int PROD_W = GAIN_BITS + SAMPLE_BITS + 1;
   localparam int CAL_W  = PROD_W + 1;
   localparam int PIXEL_MAX = (1 << PIXEL_BITS) - 1;

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] buf_ff [N];
   logic [SAMPLE_BITS-1:0] buf_in [N];
   group_type              grp_ff;
   logic [CW-1:0]          cnt_ff;
   logic [SUM_W-1:0]       acc_ff;
   logic [QW-1:0]          quot_ff;
   logic [SAMPLE_BITS-1:0] fx_ff, fy_ff, sx_ff, sy_ff, mx_ff, my_ff;
   logic                   ok_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [PIXEL_BITS-1:0]  held_x_ff, held_y_ff;
   logic                   out_valid_ff;
   logic [PIXEL_BITS-1:0]  out_x_ff, out_y_ff;
   logic                   out_acc_ff;

   // strobes from the output decoder
   logic buf_load, sort_step, sum_step, div_step, avg_step, check_step;
   logic mul_step, cal_x_step, cal_y_step, out_load, cnt_done, out_free;

   logic                   in_range, agree_now;
   logic [SAMPLE_BITS-1:0] avg, dx, dy, mx_in, my_in;
   logic signed [GAIN_BITS-1:0] mul_gain;
   logic [SAMPLE_BITS-1:0] mul_val;
   logic signed [CAL_W-1:0] cal_x_val, cal_y_val;

   function automatic logic [PIXEL_BITS-1:0] clamp_pixel(input logic signed [CAL_W-1:0] v);
      logic signed [CAL_W-1:0] sh;
      sh = v >>> FRAC_BITS;
      if (v[CAL_W-1]) begin
         return '0;
      end else if (sh > CAL_W'(PIXEL_MAX)) begin
         return '1;
      end
      return sh[PIXEL_BITS-1:0];
   endfunction

   assign cnt_done = (cnt_ff == CW'(N - 1));
   assign out_free = !out_valid_ff || out_ready;

   // ---- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (!qstat.empty) state_in = ST_SORT;
         ST_SORT:  if (cnt_done) state_in = ST_SUM;
         ST_SUM:   if (cnt_done) state_in = ST_DIV;
         ST_DIV:   state_in = ST_AVG;
         ST_AVG:   state_in = (grp_ff == GRP_Y2) ? ST_CHECK : ST_IDLE;
         ST_CHECK: state_in = agree_now ? ST_MUL_X : ST_OUT;
         ST_MUL_X: state_in = ST_CAL_X;
         ST_CAL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_CAL_Y;
         ST_CAL_Y: state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---- outputs of the sequencer
   always_comb begin
      buf_load   = 1'b0;
      sort_step  = 1'b0;
      sum_step   = 1'b0;
      div_step   = 1'b0;
      avg_step   = 1'b0;
      check_step = 1'b0;
      mul_step   = 1'b0;
      cal_x_step = 1'b0;
      cal_y_step = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:  buf_load   = !qstat.empty;
         ST_SORT:  sort_step  = 1'b1;
         ST_SUM:   sum_step   = 1'b1;
         ST_DIV:   div_step   = 1'b1;
         ST_AVG:   avg_step   = 1'b1;
         ST_CHECK: check_step = 1'b1;
         ST_MUL_X: mul_step   = 1'b1;
         ST_CAL_X: cal_x_step = 1'b1;
         ST_MUL_Y: mul_step   = 1'b1;
         ST_CAL_Y: cal_y_step = 1'b1;
         ST_OUT:   out_load   = out_free;
         default:  ;
      endcase
      job_pop = buf_load;
   end

   // ---- datapath
   // one odd-even transposition pass per cycle, or a shift toward slot 0 while summing
   always_comb begin
      buf_in = buf_ff;
      if (sort_step) begin
         for (int i = 0; i + 1 < N; i++) begin
            if ((1'(i) == cnt_ff[0]) && (buf_ff[i] > buf_ff[i+1])) begin
               buf_in[i]   = buf_ff[i+1];
               buf_in[i+1] = buf_ff[i];
            end
         end
      end else if (sum_step) begin
         for (int i = 0; i + 1 < N; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
      end
   end

   always_comb begin
      in_range  = (cnt_ff >= CW'(T_EFF)) && (cnt_ff <= CW'(N - 1 - T_EFF));
      avg       = quot_ff[SH +: SAMPLE_BITS];
      dx        = (fx_ff > sx_ff) ? fx_ff - sx_ff : sx_ff - fx_ff;
      dy        = (fy_ff > sy_ff) ? fy_ff - sy_ff : sy_ff - fy_ff;
      agree_now = (dx < cfg.agree_window) && (dy < cfg.agree_window);
      mx_in     = SAMPLE_BITS'(({1'b0, fx_ff} + {1'b0, sx_ff}) >> 1);
      my_in     = SAMPLE_BITS'(({1'b0, fy_ff} + {1'b0, sy_ff}) >> 1);
      mul_gain  = (state_ff == ST_MUL_X) ? cfg.x_gain : cfg.y_gain;
      mul_val   = (state_ff == ST_MUL_X) ? mx_ff : my_ff;
      prod_in   = mul_gain * $signed({1'b0, mul_val});
      cal_x_val = CAL_W'(prod_ff) + (CAL_W'(cfg.x_offset) <<< FRAC_BITS);
      cal_y_val = CAL_W'(prod_ff) + (CAL_W'(cfg.y_offset) <<< FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         fx_ff        <= '0;
         fy_ff        <= '0;
         sx_ff        <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (avg_step) begin
            unique case (grp_ff)
               GRP_X1:  fx_ff <= avg;
               GRP_Y1:  fy_ff <= avg;
               GRP_X2:  sx_ff <= avg;
               GRP_Y2:  ;
               default: ;
            endcase
         end
         if (cal_x_step) held_x_ff <= clamp_pixel(cal_x_val);
         if (cal_y_step) held_y_ff <= clamp_pixel(cal_y_val);
      end
   end

   always_ff @(posedge clock) begin
      if (buf_load) begin
         for (int i = 0; i < N; i++) begin
            buf_ff[i] <= job_data[i*SAMPLE_BITS +: SAMPLE_BITS];
         end
         grp_ff <= group_type'(job_data[N*SAMPLE_BITS +: GROUP_BITS]);
      end else begin
         buf_ff <= buf_in;
      end
      if (buf_load || (sort_step && cnt_done)) begin
         cnt_ff <= '0;
      end else if (sort_step || sum_step) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (buf_load) begin
         acc_ff <= '0;
      end else if (sum_step && in_range) begin
         acc_ff <= acc_ff + SUM_W'(buf_ff[0]);
      end
      // divide by the constant count through a scaled reciprocal
      if (div_step) quot_ff <= QW'(acc_ff) * QW'(RECIP);
      if (avg_step && grp_ff == GRP_Y2) sy_ff <= avg;
      if (check_step) begin
         ok_ff <= agree_now;
         mx_ff <= mx_in;
         my_ff <= my_in;
      end
      if (mul_step) prod_ff <= prod_in;
      if (out_load) begin
         out_x_ff   <= held_x_ff;
         out_y_ff   <= held_y_ff;
         out_acc_ff <= ok_ff;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_x        = out_x_ff;
   assign out_y        = out_y_ff;
   assign out_accepted = out_acc_ff;

endmodule

`default_nettype wire

// File: design/touch_sample_filter_calibrate_unit.sv
// Top level of the touch sample filter and calibration unit: configuration registers,
// front (tsfc_front), job queue (tsfc_queue) and back (tsfc_back). Uses tsfc_pkg.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tdata: sample[11:0]; tuser: restart
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata: x_pixel[15:0], y_pixel[31:16];
//          |           |                        | tuser: accepted
//  csr     | in        | csr_we                 | csr_addr index, csr_wdata value
//
// The front takes one reading per cycle while the two-entry job queue has room.
// The back works through one group of N readings at a time (sort passes, one summing shift
// per reading, reciprocal multiply, store), and on the last group of a frame adds the
// agreement check, two multiply/offset steps and the output load; it takes the next
// group from the queue only when it is through with the current one.
// Reset is synchronous; a held result stalls the back, and the front keeps filling the queue until it is full.
`default_nettype none

module touch_sample_filter_calibrate_unit #(
   parameter int SAMPLES_PER_AXIS = 5,
   parameter int TRIM_COUNT       = 1
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [tsfc_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // sample[11:0], zero pad
   input  wire logic                                 req_tuser,  // restart
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [tsfc_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,  // x_pixel, y_pixel
   output logic                                      rsp_tuser,  // accepted
   input  wire logic                                 csr_we,
   input  wire logic [tsfc_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [tsfc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import tsfc_pkg::*;

   localparam int JOB_W = SAMPLES_PER_AXIS * SAMPLE_BITS + GROUP_BITS;

   cfg_type          cfg_ff;
   queue_status_type qstat;
   logic             push, job_pop;
   logic [JOB_W-1:0] push_data, job_data;
   logic [PIXEL_BITS-1:0] x_pixel, y_pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_gain       <= GAIN_BITS'(5243);
         cfg_ff.y_gain       <= GAIN_BITS'(3932);
         cfg_ff.x_offset     <= -OFFSET_BITS'(15);
         cfg_ff.y_offset     <= -OFFSET_BITS'(20);
         cfg_ff.agree_window <= WINDOW_BITS'(100);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_X_GAIN:       cfg_ff.x_gain       <= csr_wdata[GAIN_BITS-1:0];
            CSR_Y_GAIN:       cfg_ff.y_gain       <= csr_wdata[GAIN_BITS-1:0];
            CSR_X_OFFSET:     cfg_ff.x_offset     <= csr_wdata[OFFSET_BITS-1:0];
            CSR_Y_OFFSET:     cfg_ff.y_offset     <= csr_wdata[OFFSET_BITS-1:0];
            CSR_AGREE_WINDOW: cfg_ff.agree_window <= csr_wdata[WINDOW_BITS-1:0];
            default:          ;
         endcase
      end
   end

   tsfc_front #(
      .N (SAMPLES_PER_AXIS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .in_restart (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .push_data  (push_data)
   );

   tsfc_queue #(
      .W (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (job_pop),
      .pop_data  (job_data),
      .qstat     (qstat)
   );

   tsfc_back #(
      .N (SAMPLES_PER_AXIS),
      .T (TRIM_COUNT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .qstat        (qstat),
      .job_data     (job_data),
      .job_pop      (job_pop),
      .cfg          (cfg_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_x        (x_pixel),
      .out_y        (y_pixel),
      .out_accepted (rsp_tuser)
   );

   assign rsp_tdata = {y_pixel, x_pixel};

endmodule

`default_nettype wire

// File: design/tsfc_checker.sv
// tsfc_checker: port-level assertions on the result channel of the top level.
// Bound to touch_sample_filter_calibrate_unit below; uses tsfc_pkg for widths.
`default_nettype none

module tsfc_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [tsfc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic                               rsp_tuser
);
   import tsfc_pkg::*;

   // coordinates of the last delivered word; a rejected frame must repeat them
   logic [RSP_DATA_BITS-1:0] last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         last_ff <= rsp_tdata;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_reject_repeats: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == last_ff)
      else $error("rejected frame did not repeat held coordinates");

endmodule

bind touch_sample_filter_calibrate_unit tsfc_checker u_tsfc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
